// File: rtl/prd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_pkg
// Shared widths, constants, register codes and types of the pulse rate
// detector.
// ----------------------------------------------------------------------------
package prd_pkg;

	localparam int WINDOW     = 50;
	localparam int FILL_W     = $clog2(WINDOW + 1);

	localparam int SAMPLE_W   = 12;
	localparam int GATE_W     = 11;
	localparam int TICK_W     = 16;
	localparam int PERIOD_W   = 10;
	localparam int BPM_W      = 8;
	localparam int PROD_W     = TICK_W + PERIOD_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam int DIV_W      = 16;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam logic [DIV_W-1:0] RATE_NUMERATOR = DIV_W'(60000);

	localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(20);
	localparam logic [BPM_W-1:0]    FLOOR_RST   = BPM_W'(30);
	localparam logic [BPM_W-1:0]    CEILING_RST = BPM_W'(200);
	localparam logic [BPM_W-1:0]    RLOW_RST    = BPM_W'(60);
	localparam logic [BPM_W-1:0]    RHIGH_RST   = BPM_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD  = 3'd0,
		REG_FLOOR   = 3'd1,
		REG_CEILING = 3'd2,
		REG_RLOW    = 3'd3,
		REG_RHIGH   = 3'd4
	} prd_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} prd_div_stat_t;

endpackage

// File: rtl/prd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_if
// Valid/ready channels of the pulse rate detector: sample, result and
// configuration write.
// ----------------------------------------------------------------------------
interface prd_sample_if import prd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface prd_result_if import prd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                beat_edge;
	logic [BPM_W-1:0]    bpm;
	logic                report_valid;
	logic                led_level;
	logic [SAMPLE_W-1:0] midpoint;

	modport source (output valid, output beat_edge, output bpm, output report_valid,
		output led_level, output midpoint, input ready);
	modport sink   (input valid, input beat_edge, input bpm, input report_valid,
		input led_level, input midpoint, output ready);
endinterface

interface prd_cfg_if import prd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/prd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_div
// Restoring serial divider: RATE_NUMERATOR / divisor, one quotient bit per
// cycle. Divisor must be nonzero and held stable while busy.
// ----------------------------------------------------------------------------
module prd_div import prd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output prd_div_stat_t    stat
);

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     num_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       trial;
	logic                 fits;
	logic [DIV_W:0]       diff;

	// shift in the next numerator bit and try the subtract
	assign trial = {rem_q, num_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= RATE_NUMERATOR;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			num_q <= {num_q[DIV_W-2:0], fits};
		end
	end

	assign quotient  = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $fell(busy_q))
		else $error("divider done without finishing a pass");

endmodule

// File: rtl/pulse_rate_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_rate_detector_unit
// Adaptive-threshold heart rate detector: batch max/min tracking, midpoint
// crossing detection, beat interval timing and a serial rate divider.
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  --------+--------+-----------------------------------------------------
//  smp     | sink   | sample[11:0]
//  res     | source | beat_edge, bpm[7:0], report_valid, led_level,
//          |        | midpoint[11:0]
//  cfg     | sink   | index[2:0], data[9:0]; ready is always high
//
// One word on smp yields exactly one word on res.
// A plain sample passes the batch, crossing and finish steps before the next
// accept, its result word registered at the finish step; an even crossing that
// measures a new rate also passes the multiply, 16-step serial divider and clamp
// steps, and one with a zero interval skips the divider.
// smp is ready only in the idle state; a finished result sits in the
// output register so the next sample can be taken while it waits.
// A stalled res holds the sequencer in its final step until the slot frees.
// arst_n clears all control and detector state; no clearing pass.
// ----------------------------------------------------------------------------
module pulse_rate_detector_unit import prd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	prd_sample_if.sink    smp,
	prd_result_if.source  res,
	prd_cfg_if.sink       cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BATCH,
		S_CROSS,
		S_MULT,
		S_DIV,
		S_CLAMP,
		S_FINISH
	} state_t;

	state_t state_q;

	logic [PERIOD_W-1:0] period_q;
	logic [BPM_W-1:0]    floor_q;
	logic [BPM_W-1:0]    ceiling_q;
	logic [BPM_W-1:0]    rlow_q;
	logic [BPM_W-1:0]    rhigh_q;

	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] mid_q;
	logic [GATE_W-1:0]   gate_q;
	logic                above_q;
	logic                parity_q;
	logic [TICK_W-1:0]   tick_q;
	logic [TICK_W-1:0]   stamp_q;
	logic [BPM_W-1:0]    bpm_q;
	logic                led_q;
	logic                edge_q;
	logic [TICK_W-1:0]   span_q;
	logic [DIV_W-1:0]    interval_q;

	logic                res_valid_q;
	logic                res_edge_q;
	logic [BPM_W-1:0]    res_bpm_q;
	logic                res_report_q;
	logic                res_led_q;
	logic [SAMPLE_W-1:0] res_mid_q;

	logic signed [SAMPLE_W:0] rise;
	logic signed [SAMPLE_W:0] gate_ext;
	logic                     take;
	logic [SAMPLE_W-1:0]      max_nx;
	logic [SAMPLE_W-1:0]      min_nx;
	logic [FILL_W-1:0]        fill_inc;
	logic [SAMPLE_W:0]        mid_sum;
	logic [SAMPLE_W-1:0]      spread;
	logic                     now_above;
	logic [PROD_W-1:0]        product;
	logic [DIV_W-1:0]         product_sat;
	logic [DIV_W-1:0]         rate;
	logic [DIV_W-1:0]         rate_top;
	logic [BPM_W-1:0]         rate_clamped;
	logic                     report;
	logic                     slot_free;
	logic                     div_start;
	logic [DIV_W-1:0]         quotient;
	prd_div_stat_t            div_stat;

	// batch step
	assign rise     = $signed({1'b0, sample_q}) - $signed({1'b0, prev_q});
	assign gate_ext = $signed({2'b00, gate_q});
	assign take     = rise < gate_ext;
	assign max_nx   = (fill_q == '0 || sample_q > max_q) ? sample_q : max_q;
	assign min_nx   = (fill_q == '0 || sample_q < min_q) ? sample_q : min_q;
	assign fill_inc = fill_q + 1'b1;
	assign mid_sum  = {1'b0, max_nx} + {1'b0, min_nx};
	assign spread   = max_nx - min_nx;

	assign now_above = sample_q > mid_q;

	// interval = tick span times period, saturated to 16 bits
	assign product     = PROD_W'(span_q) * PROD_W'(period_q);
	assign product_sat = (product[PROD_W-1:DIV_W] != '0) ? {DIV_W{1'b1}}
		: product[DIV_W-1:0];
	assign div_start   = (state_q == S_MULT) && (product_sat != '0);

	// zero interval means no divide: take the ceiling
	assign rate         = (interval_q == '0) ? DIV_W'(ceiling_q) : quotient;
	assign rate_top     = (rate > DIV_W'(ceiling_q)) ? DIV_W'(ceiling_q) : rate;
	assign rate_clamped = (rate_top < DIV_W'(floor_q)) ? floor_q : rate_top[BPM_W-1:0];

	assign report    = edge_q && (bpm_q >= rlow_q) && (bpm_q <= rhigh_q);
	assign slot_free = !res_valid_q || res.ready;

	prd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (interval_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RST;
			floor_q   <= FLOOR_RST;
			ceiling_q <= CEILING_RST;
			rlow_q    <= RLOW_RST;
			rhigh_q   <= RHIGH_RST;
		end else if (cfg.valid) begin
			case (prd_reg_t'(cfg.index))
				REG_PERIOD:  period_q  <= cfg.data;
				REG_FLOOR:   floor_q   <= cfg.data[BPM_W-1:0];
				REG_CEILING: ceiling_q <= cfg.data[BPM_W-1:0];
				REG_RLOW:    rlow_q    <= cfg.data[BPM_W-1:0];
				REG_RHIGH:   rhigh_q   <= cfg.data[BPM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sample_q     <= '0;
			prev_q       <= '0;
			fill_q       <= '0;
			max_q        <= '0;
			min_q        <= '0;
			mid_q        <= '0;
			gate_q       <= '0;
			above_q      <= 1'b0;
			parity_q     <= 1'b0;
			tick_q       <= '0;
			stamp_q      <= '0;
			bpm_q        <= '0;
			led_q        <= 1'b0;
			edge_q       <= 1'b0;
			span_q       <= '0;
			interval_q   <= '0;
			res_valid_q  <= 1'b0;
			res_edge_q   <= 1'b0;
			res_bpm_q    <= '0;
			res_report_q <= 1'b0;
			res_led_q    <= 1'b0;
			res_mid_q    <= '0;
		end else begin
			// raise on a finished word, drop once the word is taken
			if (state_q == S_FINISH && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (smp.valid) begin
						sample_q <= smp.sample;
						state_q  <= S_BATCH;
					end
				end
				S_BATCH: begin
					prev_q <= sample_q;
					if (take) begin
						max_q <= max_nx;
						min_q <= min_nx;
						if (FILL_W'(WINDOW) <= fill_inc) begin
							fill_q <= '0;
							mid_q  <= mid_sum[SAMPLE_W:1];
							gate_q <= spread[SAMPLE_W-1:1];
						end else begin
							fill_q <= fill_inc;
						end
					end
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					above_q <= now_above;
					edge_q  <= !above_q && now_above;
					state_q <= S_FINISH;
					if (!above_q && now_above) begin
						parity_q <= !parity_q;
						if (!parity_q) begin
							stamp_q <= tick_q;
							led_q   <= 1'b0;
						end else begin
							led_q  <= 1'b1;
							tick_q <= '0;
							span_q <= tick_q - stamp_q;
							if (tick_q > stamp_q) begin
								state_q <= S_MULT;
							end
						end
					end
				end
				S_MULT: begin
					interval_q <= product_sat;
					state_q    <= (product_sat != '0) ? S_DIV : S_CLAMP;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					bpm_q   <= rate_clamped;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// hold until the output slot frees
					if (slot_free) begin
						res_edge_q   <= edge_q;
						res_bpm_q    <= bpm_q;
						res_report_q <= report;
						res_led_q    <= led_q;
						res_mid_q    <= mid_q;
						tick_q       <= tick_q + 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign smp.ready        = (state_q == S_IDLE);
	assign res.valid        = res_valid_q;
	assign res.beat_edge    = res_edge_q;
	assign res.bpm          = res_bpm_q;
	assign res.report_valid = res_report_q;
	assign res.led_level    = res_led_q;
	assign res.midpoint     = res_mid_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FILL_W'(WINDOW))
		else $error("batch fill count reached the window size");
	a_bpm_only_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(bpm_q != $past(bpm_q)) |-> ($past(state_q) == S_CLAMP))
		else $error("bpm changed outside the clamp step");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");
	a_report_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_report_q) |-> res_edge_q)
		else $error("report raised without a beat edge");
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && slot_free) |=> (res_valid_q && state_q == S_IDLE))
		else $error("finished word not loaded into the output slot");

endmodule
